[rtl/mstd_pkg.sv]
// Package: state encoding and fixed widths for the mean and standard deviation unit
`timescale 1ns / 1ps
`default_nettype none

package mstd_pkg;

    localparam int DATA_W     = 32;
    localparam int DEV_W      = 64;
    localparam int ROOT_W     = DEV_W / 2;
    localparam int STEP_W     = 6;
    localparam int DIV_STEPS  = DEV_W;
    localparam int SQRT_STEPS = ROOT_W;

    localparam logic [DATA_W-1:0] SD_MAX    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MARKER_RST = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_MEAN,
        ST_MEAN_FIN,
        ST_DEV_RD,
        ST_DEV_LD,
        ST_DEV_MUL,
        ST_VAR_PREP,
        ST_DIV_VAR,
        ST_SQRT_PREP,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/mean_and_std_deviation_unit.sv]
// Top level: population mean and standard deviation over a set of Q16.16 samples
//
// Input channel (i_in_valid / o_in_stall) carries one sample per item with a last flag.
// Samples load one per cycle while the unit is idle. A sample equal to the marker
// register is skipped; samples past MAX_SAMPLES in a set are ignored.
// The config channel (i_cfg_valid / o_cfg_ready) writes the marker; it is always ready.
// On the item with last set, input stalls while the unit works through the set:
//   prepare and divide for the mean, read back each stored sample and square its
//   deviation with a shift-add multiplier, divide for the variance, take the
//   square root two bits per cycle, then write the result.
//   A set with no valid sample goes from prepare straight to the result write.
// Results leave through an output register (o_out_valid / i_out_stall); a new set
// loads while a result waits, and the unit holds at set end until the register frees.
// Synchronous active-low reset clears control, set counters and sums, and sets the
// marker to the most negative value. Stored samples are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module mean_and_std_deviation_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  signed [mstd_pkg::DATA_W-1:0] i_sample,
    input  wire                          i_last,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  signed [mstd_pkg::DATA_W-1:0] i_cfg_data,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic signed [mstd_pkg::DATA_W-1:0] o_mean,
    output logic signed [mstd_pkg::DATA_W-1:0] o_std_dev,
    output logic                         o_valid_res
);

    import mstd_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW = DATA_W + CW;

    t_state r_state;
    t_state n_state;

    logic [DATA_W-1:0] r_store [MAX_SAMPLES];
    logic [DATA_W-1:0] r_rd_data;

    logic [DATA_W-1:0] r_marker;
    logic [CW-1:0]     r_stored_cnt;
    logic [CW-1:0]     r_valid_cnt;
    logic [SW-1:0]     r_sum;
    logic [DEV_W-1:0]  r_dev;
    logic [CW-1:0]     r_idx;
    logic [DATA_W-1:0] r_mean;

    logic [DEV_W-1:0]  r_dq;
    logic [CW-1:0]     r_rem;
    logic [STEP_W-1:0] r_step;

    logic [DEV_W-1:0]  r_mcand;
    logic [DATA_W-1:0] r_mplier;

    logic [DEV_W-1:0]  r_sq_v;
    logic [ROOT_W+1:0] r_sq_rem;
    logic [ROOT_W-1:0] r_root;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_mean;
    logic [DATA_W-1:0] r_out_sd;
    logic              r_out_vres;

    logic              w_in_acc;
    logic              w_room;
    logic              w_keep;
    logic              w_out_free;
    logic              w_div_run;
    logic              w_out_load;

    logic [SW-1:0]     w_mag;
    logic [SW-1:0]     w_num;
    logic [CW:0]       w_trial;
    logic [CW:0]       w_tdiff;
    logic              w_tge;
    logic [DATA_W-1:0] w_q32;
    logic [DATA_W:0]   w_d;
    logic [DATA_W:0]   w_absd;
    logic [DEV_W:0]    w_acc;
    logic [ROOT_W+3:0] w_sq_t;
    logic [ROOT_W+3:0] w_sq_try;
    logic [ROOT_W+3:0] w_sq_diff;
    logic              w_sq_ge;
    logic              w_last_idx;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_mean      = r_out_mean;
    assign o_std_dev   = r_out_sd;
    assign o_valid_res = r_out_vres;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_room     = r_stored_cnt < CW'(MAX_SAMPLES);
    assign w_keep     = w_in_acc && w_room && (i_sample != r_marker);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_idx = (r_idx + CW'(1)) == r_valid_cnt;

    assign w_mag   = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;
    assign w_num   = w_mag + SW'(r_valid_cnt >> 1);
    assign w_trial = {r_rem, r_dq[DEV_W-1]};
    assign w_tdiff = w_trial - {1'b0, r_valid_cnt};
    assign w_tge   = w_trial >= {1'b0, r_valid_cnt};
    assign w_q32   = r_dq[DATA_W-1:0];

    assign w_d    = {r_rd_data[DATA_W-1], r_rd_data} - {r_mean[DATA_W-1], r_mean};
    assign w_absd = w_d[DATA_W] ? (~w_d + (DATA_W+1)'(1)) : w_d;
    assign w_acc  = {1'b0, r_dev} + {1'b0, r_mcand};

    assign w_sq_t    = {r_sq_rem, r_sq_v[DEV_W-1:DEV_W-2]};
    assign w_sq_try  = {2'b00, r_root, 2'b01};
    assign w_sq_ge   = w_sq_t >= w_sq_try;
    assign w_sq_diff = w_sq_t - w_sq_try;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_last) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = (r_valid_cnt == '0) ? ST_DONE : ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MEAN_FIN;
                end
            end
            ST_MEAN_FIN:  n_state = ST_DEV_RD;
            ST_DEV_RD:    n_state = ST_DEV_LD;
            ST_DEV_LD:    n_state = ST_DEV_MUL;
            ST_DEV_MUL: begin
                if (r_mplier == '0) begin
                    n_state = w_last_idx ? ST_VAR_PREP : ST_DEV_RD;
                end
            end
            ST_VAR_PREP:  n_state = ST_DIV_VAR;
            ST_DIV_VAR: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SQRT_PREP;
                end
            end
            ST_SQRT_PREP: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_div_run  = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE:     o_in_stall = 1'b0;
            ST_DIV_MEAN: w_div_run  = 1'b1;
            ST_DIV_VAR:  w_div_run  = 1'b1;
            ST_DONE:     w_out_load = w_out_free;
            default:     o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_store[r_valid_cnt[AW-1:0]] <= i_sample;
        end
        r_rd_data <= r_store[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_marker     <= MARKER_RST;
            r_stored_cnt <= '0;
            r_valid_cnt  <= '0;
            r_sum        <= '0;
            r_dev        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_marker <= i_cfg_data;
            end
            if (w_in_acc && w_room) begin
                r_stored_cnt <= r_stored_cnt + CW'(1);
            end
            if (w_keep) begin
                r_valid_cnt <= r_valid_cnt + CW'(1);
                r_sum       <= r_sum + SW'(i_sample);
            end
            if (r_state == ST_MEAN_FIN) begin
                r_dev <= '0;
            end
            if (r_state == ST_DEV_MUL && r_mplier[0]) begin
                r_dev <= w_acc[DEV_W] ? {DEV_W{1'b1}} : w_acc[DEV_W-1:0];
            end
            if (w_out_load) begin
                r_out_valid  <= 1'b1;
                r_stored_cnt <= '0;
                r_valid_cnt  <= '0;
                r_sum        <= '0;
                r_dev        <= '0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_PREP: begin
                r_dq   <= {{(DEV_W-SW){1'b0}}, w_num};
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_MEAN_FIN: begin
                r_mean <= r_sum[SW-1] ? (~w_q32 + DATA_W'(1)) : w_q32;
                r_idx  <= '0;
            end
            ST_DEV_LD: begin
                r_mcand  <= {{(DEV_W-DATA_W){1'b0}}, w_absd[DATA_W-1:0]};
                r_mplier <= w_absd[DATA_W-1:0];
            end
            ST_DEV_MUL: begin
                r_mcand  <= {r_mcand[DEV_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[DATA_W-1:1]};
                if (r_mplier == '0) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            ST_VAR_PREP: begin
                r_dq   <= r_dev;
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_SQRT_PREP: begin
                r_sq_v   <= r_dq;
                r_sq_rem <= '0;
                r_root   <= '0;
                r_step   <= '0;
            end
            ST_SQRT: begin
                r_sq_v   <= {r_sq_v[DEV_W-3:0], 2'b00};
                r_step   <= r_step + STEP_W'(1);
                if (w_sq_ge) begin
                    r_sq_rem <= w_sq_diff[ROOT_W+1:0];
                    r_root   <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_sq_rem <= w_sq_t[ROOT_W+1:0];
                    r_root   <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    if (r_valid_cnt == '0) begin
                        r_out_mean <= r_marker;
                        r_out_sd   <= r_marker;
                        r_out_vres <= 1'b0;
                    end else begin
                        r_out_mean <= r_mean;
                        r_out_sd   <= r_root[ROOT_W-1] ? SD_MAX : r_root;
                        r_out_vres <= 1'b1;
                    end
                end
            end
            default: begin
                if (w_div_run) begin
                    r_dq   <= {r_dq[DEV_W-2:0], w_tge};
                    r_rem  <= w_tge ? w_tdiff[CW-1:0] : w_trial[CW-1:0];
                    r_step <= r_step + STEP_W'(1);
                end
            end
        endcase
    end

    a_valid_le_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_cnt <= r_stored_cnt)
        else $error("valid count exceeds stored count");

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored_cnt <= CW'(MAX_SAMPLES))
        else $error("stored count exceeds MAX_SAMPLES");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_MEAN || r_state == ST_DIV_VAR) |-> r_rem < r_valid_cnt)
        else $error("divider remainder not below divisor");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && r_state == ST_IDLE && r_stored_cnt == '0))
        else $error("set end did not post result and clear set");

    a_novalid_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> o_mean == o_std_dev)
        else $error("empty set result fields differ");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for the mean and standard deviation unit: random sets checked against a predictor
`timescale 1ns / 1ps

module tb_top;

    import mstd_pkg::*;

    localparam int  SET_DEPTH    = 1024;
    localparam int  CLK_PERIOD   = 4;
    localparam int  LIMIT_CYCLES = 2_000_000;
    localparam int  RANDOM_ITEMS = 550;
    localparam int  SETTLE       = 8;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [DATA_W-1:0] mean;
        logic [DATA_W-1:0] sd;
        logic              flag;
    } t_set_stats;

    class t_stats_scoreboard;
        logic [DATA_W-1:0] marker;
        logic [DATA_W-1:0] store [SET_DEPTH];
        int                n_seen;
        int                n_valid;
        longint            acc;
        t_set_stats        expected_stats [$];
        int                errors;

        function new();
            marker  = MARKER_RST;
            n_seen  = 0;
            n_valid = 0;
            acc     = 0;
            errors  = 0;
        endfunction

        function void set_marker(logic [DATA_W-1:0] v);
            marker = v;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] %s", $realtime, msg);
            end
        endfunction

        function void absorb_sample(logic [DATA_W-1:0] s, logic lst);
            t_set_stats r;
            logic [63:0] mag;
            logic [63:0] q;
            logic [63:0] m;
            logic [63:0] sq;
            logic [64:0] wide;
            logic [63:0] dsum;
            logic [63:0] variance;
            logic [63:0] root;
            logic [63:0] trial;
            longint      avg;
            longint      d;
            if (n_seen < SET_DEPTH) begin
                n_seen++;
                if (s != marker) begin
                    store[n_valid] = s;
                    n_valid++;
                    acc += longint'(signed'(s));
                end
            end
            if (!lst) return;
            if (n_valid == 0) begin
                r.mean = marker;
                r.sd   = marker;
                r.flag = 1'b0;
            end else begin
                mag = (acc < 0) ? 64'(-acc) : 64'(acc);
                q   = (mag + 64'(n_valid / 2)) / 64'(n_valid);
                avg = (acc < 0) ? -longint'(q) : longint'(q);
                dsum = '0;
                for (int i = 0; i < n_valid; i++) begin
                    d    = longint'(signed'(store[i])) - avg;
                    m    = (d < 0) ? 64'(-d) : 64'(d);
                    sq   = m * m;
                    wide = {1'b0, dsum} + {1'b0, sq};
                    dsum = wide[64] ? '1 : wide[63:0];
                end
                variance = dsum / 64'(n_valid);
                root = '0;
                for (int b = 31; b >= 0; b--) begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= variance) root = trial;
                end
                if (root > 64'(VAL_MAX)) root = 64'(VAL_MAX);
                r.mean = avg[DATA_W-1:0];
                r.sd   = root[DATA_W-1:0];
                r.flag = 1'b1;
            end
            expected_stats = {expected_stats, r};
            n_seen  = 0;
            n_valid = 0;
            acc     = 0;
        endfunction

        function void compare_stats(logic [DATA_W-1:0] mean, logic [DATA_W-1:0] sd,
                                    logic flag);
            t_set_stats e;
            if (expected_stats.size() == 0) begin
                flag_error($sformatf("unexpected result mean %h sd %h valid %b",
                                     mean, sd, flag));
                return;
            end
            e = expected_stats.pop_front();
            if (mean !== e.mean || sd !== e.sd || flag !== e.flag) begin
                flag_error($sformatf("mean exp %h got %h, sd exp %h got %h, valid exp %b got %b",
                                     e.mean, mean, e.sd, sd, e.flag, flag));
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_sample;
    logic                     i_last;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic signed [DATA_W-1:0] i_cfg_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_mean;
    logic signed [DATA_W-1:0] o_std_dev;
    logic                     o_valid_res;

    t_stats_scoreboard sb;
    bit               quiet = 1'b0;
    int               stall_cnt = 0;
    int               sent = 0;

    mean_and_std_deviation_unit #(
        .MAX_SAMPLES(SET_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_last     (i_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_mean     (o_mean),
        .o_std_dev  (o_std_dev),
        .o_valid_res(o_valid_res)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 80));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.compare_stats(o_mean, o_std_dev, o_valid_res);
        end
        if (stall_cnt == 0) stall_cnt = pick_gap();
        i_out_stall <= (stall_cnt != 0);
        if (stall_cnt != 0) stall_cnt--;
    end

    task automatic send_item(input logic [DATA_W-1:0] s, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= lst;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.absorb_sample(s, lst);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [DATA_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.set_marker(v);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return sb.marker;
        if (r < 20) begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                3: return '1;
                default: return 32'd1;
            endcase
        end
        if (r < 50) return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        return $urandom;
    endfunction

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int len;
        int r;
        bit all_missing;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_last      <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single zero, then an all-missing set under the reset marker
        send_item('0, 1'b1);
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b1);
        // rounding ties, both signs
        send_item(32'd1, 1'b0);
        send_item(32'd2, 1'b1);
        send_item('1, 1'b0);
        send_item(-32'sd2, 1'b1);
        drain();
        write_marker('0);
        // extremes alternate: deviation sum saturates
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item('0, 1'b0);
        for (int k = 0; k < 3; k++) begin
            send_item(VAL_MIN, 1'b0);
            send_item(VAL_MAX, 1'b0);
        end
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);
        // change the marker in the middle of a set
        send_item(32'd5, 1'b0);
        drain();
        write_marker(32'd5);
        send_item(32'd5, 1'b0);
        send_item(VAL_MIN, 1'b1);
        drain();
        write_marker(VAL_MAX);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b1);
        drain();
        write_marker(VAL_MIN);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_marker($urandom);
                    1: write_marker(VAL_MIN);
                    2: write_marker(VAL_MAX);
                    default: write_marker(32'($urandom_range(0, 15)));
                endcase
            end
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 6);
            else if (r < 92) len = $urandom_range(7, 24);
            else len = $urandom_range(25, 64);
            all_missing = ($urandom_range(0, 15) == 0);
            for (int k = 0; k < len; k++) begin
                send_item(all_missing ? sb.marker : pick_sample(), k == len - 1);
            end
        end
        quiet = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
